@@ rtl/lpdf_pkg.sv @@
// Shared types and constants for the length-prefixed packet deframer.
package lpdf_pkg;

  localparam logic [7:0] LEAD_SHORT_A = 8'hC1;
  localparam logic [7:0] LEAD_SHORT_B = 8'hC3;
  localparam logic [7:0] LEAD_LONG_A  = 8'hC2;
  localparam logic [7:0] LEAD_LONG_B  = 8'hC4;

  localparam logic [15:0] HDR_SHORT = 16'd3;
  localparam logic [15:0] HDR_LONG  = 16'd4;
  localparam logic [15:0] MAX_BYTES_RESET = 16'd8192;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BADLEAD = 3'd1;
  localparam logic [2:0] ST_SHORT   = 3'd2;
  localparam logic [2:0] ST_LONG    = 3'd3;
  localparam logic [2:0] ST_CLOSED  = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } rx_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        in_packet;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] packet_length;
    logic [7:0]  command_code;
    logic [2:0]  status;
  } pkt_item_t;

endpackage

@@ rtl/length_prefixed_packet_deframer_core.sv @@
// Top level of the length-prefixed packet deframer.
//
//   channel  signals                        dir  takes place when
//   rx       rx_valid, rx_stall, rx_item    in   rx_valid && !rx_stall
//   pkt      pkt_valid, pkt_stall, pkt_item out  pkt_valid && !pkt_stall
//   cfg      cfg_valid, cfg_ready, cfg_data in   cfg_valid && cfg_ready
//
// One byte per clock while rx_stall is low: each accepted item is framed by the
// parser's logic in the cycle it arrives, and its result is registered for pkt.
// Reset (rst, synchronous) empties both output stages, sets the framer to
// hunting and loads the maximum length register with 8192.
// When pkt stalls, the result waiting there holds and one more item lands in
// the skid stage; rx_stall then rises until the skid drains.
// cfg_ready stays high; write the limit only while the block is idle.
module length_prefixed_packet_deframer_core import lpdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  rx_item_t    rx_item,
  output logic        pkt_valid,
  input  logic        pkt_stall,
  output pkt_item_t   pkt_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic        take;
  logic [15:0] max_bytes;
  pkt_item_t   result;
  logic        buf_full;

  // stall only while the skid stage holds an item
  assign rx_stall  = buf_full;
  assign take      = rx_valid && !buf_full;
  assign cfg_ready = 1'b1;

  // hold the configured length limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= MAX_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_bytes <= cfg_data;
    end
  end

  lpdf_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (rx_item),
    .max_bytes (max_bytes),
    .result    (result)
  );

  lpdf_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .load_item (result),
    .full      (buf_full),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .pkt_item  (pkt_item)
  );

endmodule

@@ rtl/lpdf_parser.sv @@
// Framing state machine: builds the result for each accepted byte.
module lpdf_parser import lpdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  rx_item_t    item,
  input  logic [15:0] max_bytes,
  output pkt_item_t   result
);

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_LEN1  = 3'd1;
  localparam logic [2:0] PH_LENHI = 3'd2;
  localparam logic [2:0] PH_LENLO = 3'd3;
  localparam logic [2:0] PH_CMD   = 3'd4;
  localparam logic [2:0] PH_BODY  = 3'd5;

  logic [2:0]  phase, phase_next;
  logic        long_form, long_form_next;
  logic [15:0] total_length, total_length_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [7:0]  command_byte, command_byte_next;
  logic        error_sticky, error_sticky_next;

  // state as seen by this byte, after an optional restart
  logic [2:0]  cur_phase;
  logic        cur_long;
  logic [15:0] cur_total;
  logic [15:0] cur_seen;
  logic [7:0]  cur_cmd;
  logic        cur_err;
  logic [15:0] seen_inc;
  logic [15:0] new_len;
  logic [15:0] header;
  logic [2:0]  len_status;
  logic [7:0]  b;

  always_comb begin
    b         = item.data_byte;
    cur_phase = item.restart ? PH_HUNT : phase;
    cur_long  = item.restart ? 1'b0    : long_form;
    cur_total = item.restart ? 16'd0   : total_length;
    cur_seen  = item.restart ? 16'd0   : bytes_seen;
    cur_cmd   = item.restart ? 8'd0    : command_byte;
    cur_err   = item.restart ? 1'b0    : error_sticky;
    seen_inc  = cur_seen + 16'd1;

    // completed length: one byte for the short form, low byte joins high
    new_len = (cur_phase == PH_LEN1) ? {8'd0, b} : {cur_total[15:8], b};
    header  = cur_long ? HDR_LONG : HDR_SHORT;
    if (new_len < header) begin
      len_status = ST_SHORT;
    end else if (new_len > max_bytes) begin
      len_status = ST_LONG;
    end else begin
      len_status = ST_OK;
    end

    phase_next        = cur_phase;
    long_form_next    = cur_long;
    total_length_next = cur_total;
    bytes_seen_next   = cur_seen;
    command_byte_next = cur_cmd;
    error_sticky_next = cur_err;

    result               = '0;
    result.out_byte      = b;
    result.status        = ST_OK;

    if (cur_err) begin
      result.status = ST_CLOSED;
    end else begin
      result.in_packet = 1'b1;
      unique case (cur_phase)
        PH_HUNT: begin
          if (b == LEAD_SHORT_A || b == LEAD_SHORT_B) begin
            long_form_next    = 1'b0;
            phase_next        = PH_LEN1;
            result.first_byte = 1'b1;
          end else if (b == LEAD_LONG_A || b == LEAD_LONG_B) begin
            long_form_next    = 1'b1;
            phase_next        = PH_LENHI;
            result.first_byte = 1'b1;
          end else begin
            result.status = ST_BADLEAD;
          end
          total_length_next = 16'd0;
          command_byte_next = 8'd0;
          bytes_seen_next   = 16'd1;
        end
        PH_LEN1, PH_LENLO: begin
          total_length_next = new_len;
          bytes_seen_next   = seen_inc;
          result.status     = len_status;
          phase_next        = PH_CMD;
        end
        PH_LENHI: begin
          total_length_next = {b, 8'd0};
          bytes_seen_next   = seen_inc;
          phase_next        = PH_LENLO;
        end
        PH_CMD, PH_BODY: begin
          if (cur_phase == PH_CMD) begin
            command_byte_next = b;
          end
          if (seen_inc >= cur_total) begin
            result.last_byte     = 1'b1;
            result.packet_length = cur_total;
            result.command_code  = (cur_phase == PH_CMD) ? b : cur_cmd;
            phase_next           = PH_HUNT;
            bytes_seen_next      = 16'd0;
          end else begin
            bytes_seen_next = seen_inc;
            phase_next      = PH_BODY;
          end
        end
        default: begin
          phase_next       = PH_HUNT;
          result.in_packet = 1'b0;
        end
      endcase
      if (result.status != ST_OK) begin
        error_sticky_next = 1'b1;
        result.in_packet  = 1'b0;
        result.first_byte = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      long_form    <= 1'b0;
      total_length <= 16'd0;
      bytes_seen   <= 16'd0;
      command_byte <= 8'd0;
      error_sticky <= 1'b0;
    end else if (take) begin
      phase        <= phase_next;
      long_form    <= long_form_next;
      total_length <= total_length_next;
      bytes_seen   <= bytes_seen_next;
      command_byte <= command_byte_next;
      error_sticky <= error_sticky_next;
    end
  end

endmodule

@@ rtl/lpdf_out_buf.sv @@
// Result register with a skid stage so the input stall is registered.
module lpdf_out_buf import lpdf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  pkt_item_t load_item,
  output logic      full,
  output logic      pkt_valid,
  input  logic      pkt_stall,
  output pkt_item_t pkt_item
);

  logic      skid_valid;
  pkt_item_t skid_item;
  logic      advance;

  assign full    = skid_valid;
  assign advance = !pkt_valid || !pkt_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (advance) begin
        pkt_valid  <= skid_valid || load;
        skid_valid <= 1'b0;
      end else if (load) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pkt_item <= skid_valid ? skid_item : load_item;
    end else if (load) begin
      skid_item <= load_item;
    end
  end

endmodule

@@ rtl/lpdf_checker.sv @@
// Port-level assertions for the deframer, bound to the top level.
module lpdf_checker import lpdf_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      rx_stall,
  input logic      pkt_valid,
  input logic      pkt_stall,
  input pkt_item_t pkt_item
);

  // output is empty and input open right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !pkt_valid && !rx_stall)
    else $error("pkt_valid or rx_stall high after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && pkt_stall |=> pkt_valid && $stable(pkt_item))
    else $error("stalled result changed");

  // a completed packet is always a good one
  a_last_ok: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && pkt_item.last_byte |->
      pkt_item.in_packet && pkt_item.status == ST_OK && !pkt_item.first_byte)
    else $error("last byte with bad status");

  // closed stream reports nothing else
  a_closed: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && pkt_item.status == ST_CLOSED |->
      !pkt_item.in_packet && !pkt_item.first_byte && !pkt_item.last_byte &&
      pkt_item.packet_length == 16'd0 && pkt_item.command_code == 8'd0)
    else $error("closed result carries packet marks");

  // an error byte is never part of a packet
  a_err_out: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && pkt_item.status != ST_OK |-> !pkt_item.in_packet)
    else $error("error result marked in packet");

endmodule

bind length_prefixed_packet_deframer_core lpdf_checker u_lpdf_checker (
  .clk       (clk),
  .rst       (rst),
  .rx_stall  (rx_stall),
  .pkt_valid (pkt_valid),
  .pkt_stall (pkt_stall),
  .pkt_item  (pkt_item)
);

@@ sim/tb.sv @@
// Self-checking testbench for the length-prefixed packet deframer core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lpdf_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 340;

  // Framer position, mirrored from the block's behavior.
  typedef enum logic [2:0] {
    PH_HUNT, PH_LEN1, PH_LENHI, PH_LENLO, PH_CMD, PH_BODY
  } frame_phase_t;

  // Shapes of generated packets.
  typedef enum int {PKT_GOOD, PKT_CUT, PKT_BAD_LEN} pkt_shape_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  rx_item_t    rx_item = '0;
  logic        pkt_valid;
  logic        pkt_stall = 1'b0;
  pkt_item_t   pkt_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  // Idle and stall chances, in percent.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  int unsigned items_sent = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // Framer state as the testbench expects it to be.
  frame_phase_t fr_phase;
  logic         fr_long;
  logic [15:0]  fr_len;
  logic [15:0]  fr_seen;
  logic [7:0]   fr_cmd;
  logic         fr_err;
  logic [15:0]  max_len;

  pkt_item_t expected_pkts[$];

  length_prefixed_packet_deframer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .rx_item   (rx_item),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .pkt_item  (pkt_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bound the run; a hung handshake ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Randomly hold off the result channel.
  always @(negedge clk) begin
    pkt_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic void clear_framer();
    fr_phase = PH_HUNT;
    fr_long  = 1'b0;
    fr_len   = '0;
    fr_seen  = '0;
    fr_cmd   = '0;
    fr_err   = 1'b0;
  endfunction

  // Judge a completed length: the too-small test comes first.
  function automatic logic [2:0] length_verdict();
    logic [15:0] hdr;
    hdr = fr_long ? HDR_LONG : HDR_SHORT;
    if (fr_len < hdr) return ST_SHORT;
    if (fr_len > max_len) return ST_LONG;
    return ST_OK;
  endfunction

  // Advance the expected framer by one byte and return the result item.
  function automatic pkt_item_t frame_byte(rx_item_t it);
    pkt_item_t  r;
    logic [7:0] b;
    r = '0;
    b = it.data_byte;
    r.out_byte = b;
    r.status = ST_OK;
    if (it.restart) clear_framer();
    if (fr_err) begin
      r.status = ST_CLOSED;
    end else begin
      r.in_packet = 1'b1;
      case (fr_phase)
        PH_HUNT: begin
          if (b == LEAD_SHORT_A || b == LEAD_SHORT_B) begin
            fr_long = 1'b0;
            fr_phase = PH_LEN1;
            r.first_byte = 1'b1;
          end else if (b == LEAD_LONG_A || b == LEAD_LONG_B) begin
            fr_long = 1'b1;
            fr_phase = PH_LENHI;
            r.first_byte = 1'b1;
          end else begin
            r.status = ST_BADLEAD;
          end
          fr_len = '0;
          fr_cmd = '0;
          fr_seen = 16'd1;
        end
        PH_LEN1: begin
          fr_len = {8'h00, b};
          fr_seen = fr_seen + 16'd1;
          r.status = length_verdict();
          fr_phase = PH_CMD;
        end
        PH_LENHI: begin
          fr_len = {b, 8'h00};
          fr_seen = fr_seen + 16'd1;
          fr_phase = PH_LENLO;
        end
        PH_LENLO: begin
          fr_len = fr_len | {8'h00, b};
          fr_seen = fr_seen + 16'd1;
          r.status = length_verdict();
          fr_phase = PH_CMD;
        end
        default: begin
          // command byte or body: the packet closes once the count reaches the length
          if (fr_phase == PH_CMD) fr_cmd = b;
          fr_seen = fr_seen + 16'd1;
          if (fr_seen >= fr_len) begin
            r.last_byte = 1'b1;
            r.packet_length = fr_len;
            r.command_code = fr_cmd;
            fr_phase = PH_HUNT;
            fr_seen = '0;
          end else begin
            fr_phase = PH_BODY;
          end
        end
      endcase
      if (r.status != ST_OK) begin
        fr_err = 1'b1;
        r.in_packet = 1'b0;
        r.first_byte = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic void cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Check each delivered result, then record the expectation for each accepted byte.
  always @(posedge clk) begin : check_proc
    pkt_item_t want;
    if (!rst) begin
      if (pkt_valid && !pkt_stall) begin
        if (expected_pkts.size() == 0) begin
          $error("result item with none expected: %p", pkt_item);
          fail_count++;
        end else begin
          want = expected_pkts.pop_front();
          cmp_field("out_byte", 32'(want.out_byte), 32'(pkt_item.out_byte));
          cmp_field("in_packet", 32'(want.in_packet), 32'(pkt_item.in_packet));
          cmp_field("first_byte", 32'(want.first_byte), 32'(pkt_item.first_byte));
          cmp_field("last_byte", 32'(want.last_byte), 32'(pkt_item.last_byte));
          cmp_field("packet_length", 32'(want.packet_length),
                    32'(pkt_item.packet_length));
          cmp_field("command_code", 32'(want.command_code),
                    32'(pkt_item.command_code));
          cmp_field("status", 32'(want.status), 32'(pkt_item.status));
        end
      end
      if (rx_valid && !rx_stall) expected_pkts.push_back(frame_byte(rx_item));
    end
  end

  // Send one byte; call and return at a falling edge. Valid stays high for the next item.
  task automatic send_byte(input logic [7:0] b, input logic rs = 1'b0);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_valid <= 1'b0;
      @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_item <= '{data_byte: b, restart: rs};
    do begin
      @(posedge clk);
    end while (rx_stall);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected result has come out.
  task automatic settle();
    rx_valid <= 1'b0;
    while (expected_pkts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_max_len(input logic [15:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    max_len = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Send one generated packet: whole, cut short, or with a bad length.
  task automatic send_packet(input pkt_shape_t shape, input logic rs);
    logic [7:0]  lead;
    logic [7:0]  b;
    logic        is_long;
    logic        big;
    logic [15:0] len;
    int unsigned hdr, room, n_send, lim_lo, lim_hi, i;
    big = (shape == PKT_GOOD && max_len >= 16'd300 && $urandom_range(49) == 0);
    if (big) begin
      lead = $urandom_range(1) ? LEAD_LONG_A : LEAD_LONG_B;
    end else begin
      case ($urandom_range(3))
        0: lead = LEAD_SHORT_A;
        1: lead = LEAD_SHORT_B;
        2: lead = LEAD_LONG_A;
        default: lead = LEAD_LONG_B;
      endcase
    end
    is_long = (lead == LEAD_LONG_A || lead == LEAD_LONG_B);
    hdr = is_long ? 32'(HDR_LONG) : 32'(HDR_SHORT);
    room = 32'(max_len) - hdr;
    if (room > 12) room = 12;
    if (big) len = 16'($urandom_range(300, 150));
    else len = 16'(hdr + $urandom_range(room));
    if (shape == PKT_BAD_LEN) begin
      lim_lo = 32'(max_len);
      lim_lo = lim_lo + 1;
      lim_hi = is_long ? 65535 : 255;
      if (lim_lo <= lim_hi && $urandom_range(1)) len = 16'($urandom_range(lim_hi, lim_lo));
      else len = 16'($urandom_range(hdr - 1));
    end
    case (shape)
      PKT_GOOD: n_send = 32'(len);
      PKT_CUT: n_send = $urandom_range(32'(len) - 1, 1);
      default: n_send = hdr - 1;
    endcase
    for (i = 0; i < n_send; i++) begin
      if (i == 0) b = lead;
      else if (is_long && i == 1) b = len[15:8];
      else if (i == 1 || (is_long && i == 2)) b = len[7:0];
      else b = 8'($urandom);
      send_byte(b, rs && i == 0);
    end
  endtask

  // Mostly whole packets with random content, plus noise and broken framing.
  task automatic run_random(input int unsigned n);
    int unsigned stop_at, pick;
    stop_at = items_sent + n;
    send_packet(PKT_GOOD, 1'b1);
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (fr_err) begin
        // linger closed for a while, then reopen the connection
        if (pick < 40) send_byte(8'($urandom), $urandom_range(3) == 0);
        else send_packet(PKT_GOOD, 1'b1);
      end else if (pick < 75) begin
        send_packet(PKT_GOOD, 1'b0);
      end else if (pick < 85) begin
        send_packet(PKT_CUT, 1'b0);
        send_packet(PKT_GOOD, 1'b1);
      end else if (pick < 92) begin
        send_byte(8'($urandom), 1'b0);
      end else begin
        send_packet(PKT_BAD_LEN, 1'b0);
      end
    end
    settle();
  endtask

  task automatic test_well_formed();
    // minimal short packet: command byte closes it
    send_byte(LEAD_SHORT_A);
    send_byte(8'h03);
    send_byte(8'hA5);
    // short packet with a body
    send_byte(LEAD_SHORT_B);
    send_byte(8'h05);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7E);
    // minimal long packet
    send_byte(LEAD_LONG_A);
    send_byte(8'h00);
    send_byte(8'h04);
    send_byte(8'hFF);
    // long packet with a body
    send_byte(LEAD_LONG_B);
    send_byte(8'h00);
    send_byte(8'h06);
    send_byte(8'h5A);
    send_byte(8'h11);
    send_byte(8'h22);
    settle();
  endtask

  task automatic test_framing_errors();
    send_byte(8'h00);                    // bad lead byte
    send_byte(LEAD_SHORT_A);             // stream closed
    send_byte(LEAD_SHORT_A, 1'b1);       // zero length
    send_byte(8'h00);
    send_byte(LEAD_SHORT_B, 1'b1);       // short length below header
    send_byte(8'h02);
    send_byte(LEAD_LONG_A, 1'b1);        // long length below header
    send_byte(8'h00);
    send_byte(8'h03);
    send_byte(8'hFF, 1'b1);              // restart straight onto a bad lead
    send_byte(LEAD_SHORT_A, 1'b1);       // restart in the middle of a packet
    send_byte(8'h06);
    send_byte(8'h42);
    send_byte(LEAD_LONG_B, 1'b1);
    send_byte(8'h00);
    send_byte(8'h04);
    send_byte(8'h3C);
    settle();
  endtask

  task automatic test_length_limit();
    set_max_len(16'd4);
    send_byte(LEAD_SHORT_A, 1'b1);       // short, length at the limit
    send_byte(8'h04);
    send_byte(8'h10);
    send_byte(8'h20);
    send_byte(LEAD_LONG_A);              // long, length at the limit
    send_byte(8'h00);
    send_byte(8'h04);
    send_byte(8'h30);
    send_byte(LEAD_SHORT_B);             // one above the limit
    send_byte(8'h05);
    send_byte(LEAD_LONG_B, 1'b1);        // long, far above the limit
    send_byte(8'h01);
    send_byte(8'h00);
    set_max_len(16'hFFFF);
    send_byte(LEAD_LONG_A, 1'b1);        // largest length accepted; abandon it
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(LEAD_SHORT_A, 1'b1);
    send_byte(8'h03);
    send_byte(8'h77);
    settle();
  endtask

  task automatic test_random_traffic();
    set_max_len(16'hFFFF);
    send_idle_pct = 0;
    stall_pct = 0;
    run_random(RANDOM_ITEMS / 4);
    set_max_len(16'd4);
    send_idle_pct = 65;
    stall_pct = 0;
    run_random(RANDOM_ITEMS / 4);
    set_max_len(16'($urandom_range(40, 5)));
    send_idle_pct = 0;
    stall_pct = 65;
    run_random(RANDOM_ITEMS / 4);
    set_max_len(16'd300);
    send_idle_pct = 11;
    stall_pct = 11;
    run_random(RANDOM_ITEMS / 4);
  endtask

  initial begin
    clear_framer();
    max_len = MAX_BYTES_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_well_formed();
    test_framing_errors();
    test_length_limit();
    test_random_traffic();
    settle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
